// ----- rtl/core/quaternion_to_rotation_matrix_macros.svh -----
// Assertion macros for the quaternion to rotation matrix block
`ifndef QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH

// same-cycle implication
`define Q2RM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("q2rm assertion failed");

// next-cycle implication
`define Q2RM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("q2rm assertion failed");

`endif

// ----- rtl/core/q2rm_pkg.sv -----
// Shared types and constants for the quaternion to rotation matrix block
`timescale 1ns / 1ps
package q2rm_pkg;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 16;
    localparam int PROD_W  = 32;
    localparam int N2_W    = 33;
    localparam int NUM_W   = 35;
    localparam int N_ENT   = 9;

    typedef logic signed [IN_W-1:0]   t_qin;
    typedef logic signed [OUT_W-1:0]  t_ent;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic        [N2_W-1:0]   t_mag;
    typedef logic signed [NUM_W-1:0]  t_num;
endpackage

// ----- rtl/core/q2rm_if.sv -----
// Request and result channel interfaces
`timescale 1ns / 1ps
interface q2rm_in_if;
    logic          valid;
    logic          ready;
    q2rm_pkg::t_qin q_scalar;
    q2rm_pkg::t_qin q_i;
    q2rm_pkg::t_qin q_j;
    q2rm_pkg::t_qin q_k;
    modport source (output valid, q_scalar, q_i, q_j, q_k, input ready);
    modport sink   (input valid, q_scalar, q_i, q_j, q_k, output ready);
endinterface

interface q2rm_out_if;
    logic           valid;
    logic           ready;
    q2rm_pkg::t_ent m_r0c0;
    q2rm_pkg::t_ent m_r0c1;
    q2rm_pkg::t_ent m_r0c2;
    q2rm_pkg::t_ent m_r1c0;
    q2rm_pkg::t_ent m_r1c1;
    q2rm_pkg::t_ent m_r1c2;
    q2rm_pkg::t_ent m_r2c0;
    q2rm_pkg::t_ent m_r2c1;
    q2rm_pkg::t_ent m_r2c2;
    logic           zero_norm;
    modport source (output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                    m_r2c0, m_r2c1, m_r2c2, zero_norm, input ready);
    modport sink   (input valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                    m_r2c0, m_r2c1, m_r2c2, zero_norm, output ready);
endinterface

// ----- rtl/core/q2rm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with rounding
`timescale 1ns / 1ps
module q2rm_div #(
    parameter int FRAC_BITS = 14
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  q2rm_pkg::t_mag      i_mag,
    input  q2rm_pkg::t_mag      i_den,
    input  logic                i_neg,
    output q2rm_pkg::t_ent      o_val
);
    localparam int QW   = FRAC_BITS + 2;
    localparam int N2_W = q2rm_pkg::N2_W;

    logic [N2_W-1:0] r_rem [QW];
    logic [N2_W-1:0] r_den [QW];
    logic [QW-1:0]   r_q   [QW];
    logic            r_neg [QW];

    genvar s;
    generate
        for (s = 0; s < QW; s++) begin : g_stage
            logic [N2_W:0]   w_t;
            logic            w_b;
            logic [N2_W:0]   w_d;
            logic [QW-1:0]   w_qprev;
            logic [N2_W-1:0] w_den;
            logic            w_neg;
            if (s == 0) begin : g_first
                assign w_t     = {1'b0, i_mag};
                assign w_qprev = '0;
                assign w_den   = i_den;
                assign w_neg   = i_neg;
            end else begin : g_rest
                assign w_t     = {r_rem[s-1], 1'b0};
                assign w_qprev = r_q[s-1];
                assign w_den   = r_den[s-1];
                assign w_neg   = r_neg[s-1];
            end
            assign w_b = (w_t >= {1'b0, w_den});
            assign w_d = w_b ? (w_t - {1'b0, w_den}) : w_t;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= w_d[N2_W-1:0];
                    r_den[s] <= w_den;
                    r_q[s]   <= {w_qprev[QW-2:0], w_b};
                    r_neg[s] <= w_neg;
                end
            end
        end
    endgenerate

    logic [QW:0]   w_sum;
    logic [31:0]   w_qr;
    logic [16:0]   w_qc;
    logic [16:0]   w_neg_v;
    q2rm_pkg::t_ent n_val;
    q2rm_pkg::t_ent r_val;

    always_comb begin
        w_sum   = {1'b0, r_q[QW-1]} + (QW+1)'(1);
        w_qr    = 32'(w_sum[QW:1]);
        w_qc    = (w_qr > 32'd32768) ? 17'd32768 : w_qr[16:0];
        w_neg_v = -w_qc;
        if (r_neg[QW-1]) begin
            n_val = w_neg_v[15:0];
        end else if (w_qc > 17'd32767) begin
            n_val = 16'sd32767;
        end else begin
            n_val = w_qc[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;
endmodule

// ----- rtl/core/quaternion_to_rotation_matrix.sv -----
// Throughput: one quaternion per cycle; the whole pipeline holds while a result
// waits at the output; each entry has its own OUT_FRAC_BITS + 2 stage divider.
// Reset (synchronous, active low) clears all valid bits; data registers keep contents.
// Top level: quaternion to normalized 3x3 rotation matrix
`timescale 1ns / 1ps
`include "quaternion_to_rotation_matrix_macros.svh"
module quaternion_to_rotation_matrix #(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    q2rm_in_if.sink       i_req,
    q2rm_out_if.source    o_res
);
    localparam int DLAT  = OUT_FRAC_BITS + 3;
    localparam int NW    = q2rm_pkg::NUM_W;
    localparam int N2W   = q2rm_pkg::N2_W;
    localparam int NE    = q2rm_pkg::N_ENT;
    localparam int PW    = q2rm_pkg::PROD_W;

    logic w_en;
    assign w_en        = !o_res.valid || o_res.ready;
    assign i_req.ready = w_en;

    logic r_v1, r_v2, r_v3, r_v4;
    logic [DLAT-1:0] r_vd;
    logic [DLAT-1:0] r_zd;

    q2rm_pkg::t_qin r_s, r_i, r_j, r_k;
    q2rm_pkg::t_prod r_ss, r_ii, r_jj, r_kk, r_ij, r_sk, r_ik, r_sj, r_jk, r_si;
    q2rm_pkg::t_mag  r_n2, r_n2b;
    q2rm_pkg::t_num  r_num [NE];
    q2rm_pkg::t_mag  r_mag [NE];
    logic            r_neg [NE];
    logic            r_zero3, r_zero4;
    q2rm_pkg::t_num  n_num [NE];
    q2rm_pkg::t_ent  w_ent [NE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vd <= '0;
        end else if (w_en) begin
            r_v1 <= i_req.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_vd <= {r_vd[DLAT-2:0], r_v4};
        end
    end

    always_comb begin
        n_num[0] = NW'(r_ss) + NW'(r_ii) - NW'(r_jj) - NW'(r_kk);
        n_num[1] = (NW'(r_ij) - NW'(r_sk)) <<< 1;
        n_num[2] = (NW'(r_ik) + NW'(r_sj)) <<< 1;
        n_num[3] = (NW'(r_ij) + NW'(r_sk)) <<< 1;
        n_num[4] = NW'(r_ss) - NW'(r_ii) + NW'(r_jj) - NW'(r_kk);
        n_num[5] = (NW'(r_jk) - NW'(r_si)) <<< 1;
        n_num[6] = (NW'(r_ik) - NW'(r_sj)) <<< 1;
        n_num[7] = (NW'(r_jk) + NW'(r_si)) <<< 1;
        n_num[8] = NW'(r_ss) - NW'(r_ii) - NW'(r_jj) + NW'(r_kk);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s  <= i_req.q_scalar;
            r_i  <= i_req.q_i;
            r_j  <= i_req.q_j;
            r_k  <= i_req.q_k;
            r_ss <= PW'(r_s) * PW'(r_s);
            r_ii <= PW'(r_i) * PW'(r_i);
            r_jj <= PW'(r_j) * PW'(r_j);
            r_kk <= PW'(r_k) * PW'(r_k);
            r_ij <= PW'(r_i) * PW'(r_j);
            r_sk <= PW'(r_s) * PW'(r_k);
            r_ik <= PW'(r_i) * PW'(r_k);
            r_sj <= PW'(r_s) * PW'(r_j);
            r_jk <= PW'(r_j) * PW'(r_k);
            r_si <= PW'(r_s) * PW'(r_i);
            r_n2 <= N2W'(unsigned'(r_ss)) + N2W'(unsigned'(r_ii))
                  + N2W'(unsigned'(r_jj)) + N2W'(unsigned'(r_kk));
            r_zero3 <= (r_ss == '0) && (r_ii == '0) && (r_jj == '0) && (r_kk == '0);
            r_n2b   <= r_n2;
            r_zero4 <= r_zero3;
            r_zd    <= {r_zd[DLAT-2:0], r_zero4};
        end
    end

    genvar e;
    generate
        for (e = 0; e < NE; e++) begin : g_ent
            q2rm_pkg::t_num w_abs;
            assign w_abs = r_num[e][NW-1] ? -r_num[e] : r_num[e];
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_num[e] <= n_num[e];
                    r_neg[e] <= r_num[e][NW-1];
                    r_mag[e] <= w_abs[N2W-1:0];
                end
            end
            q2rm_div #(.FRAC_BITS(OUT_FRAC_BITS)) u_div (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_mag (r_mag[e]),
                .i_den (r_n2b),
                .i_neg (r_neg[e]),
                .o_val (w_ent[e])
            );
        end
    endgenerate

    logic w_z;
    assign w_z             = r_zd[DLAT-1];
    assign o_res.valid     = r_vd[DLAT-1];
    assign o_res.zero_norm = w_z;
    assign o_res.m_r0c0    = w_z ? '0 : w_ent[0];
    assign o_res.m_r0c1    = w_z ? '0 : w_ent[1];
    assign o_res.m_r0c2    = w_z ? '0 : w_ent[2];
    assign o_res.m_r1c0    = w_z ? '0 : w_ent[3];
    assign o_res.m_r1c1    = w_z ? '0 : w_ent[4];
    assign o_res.m_r1c2    = w_z ? '0 : w_ent[5];
    assign o_res.m_r2c0    = w_z ? '0 : w_ent[6];
    assign o_res.m_r2c1    = w_z ? '0 : w_ent[7];
    assign o_res.m_r2c2    = w_z ? '0 : w_ent[8];

    `Q2RM_ASSERT_NEXT(a_req_enters, i_clk, i_rst_n, i_req.valid && i_req.ready, r_v1)
    `Q2RM_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_res.valid && !o_res.ready, o_res.valid && $stable(o_res.m_r0c0) && $stable(o_res.zero_norm))
    `Q2RM_ASSERT_NOW(a_zero_diag, i_clk, i_rst_n, o_res.valid && o_res.zero_norm, o_res.m_r0c0 == '0 && o_res.m_r1c1 == '0 && o_res.m_r2c2 == '0)
endmodule

// ----- verif/quaternion_to_rotation_matrix_tb.sv -----
// Self-checking testbench for the quaternion to rotation matrix block
`timescale 1ns / 1ps
module quaternion_to_rotation_matrix_tb;
    localparam int FRAC = 14;
    localparam int LAT  = FRAC + 7;
    localparam int N_RANDOM = 1900;

    typedef struct packed {
        q2rm_pkg::t_qin s;
        q2rm_pkg::t_qin i;
        q2rm_pkg::t_qin j;
        q2rm_pkg::t_qin k;
    } t_quat;

    typedef struct packed {
        q2rm_pkg::t_ent [q2rm_pkg::N_ENT-1:0] ent;
        logic                                 zn;
    } t_mat;

    typedef struct {
        t_quat q;
        logic  known;
        t_mat  m;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    q2rm_in_if  req_if();
    q2rm_out_if res_if();

    quaternion_to_rotation_matrix #(.OUT_FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_res(res_if.source)
    );

    t_mat   matrix_q[$];
    int     fail_cnt;
    int     send_idle_pct;
    int     recv_idle_pct;
    logic   hold_off;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic q2rm_pkg::t_ent round_entry(longint num, longint den);
        logic      neg;
        longint    mag;
        longint    prod;
        longint    quo;
        longint    rem;
        longint    res;
        neg  = num < 0;
        mag  = neg ? -num : num;
        prod = mag <<< FRAC;
        quo  = prod / den;
        rem  = prod % den;
        if (rem >= den - rem) quo++;
        if (quo > 32768) quo = 32768;
        res = neg ? -quo : quo;
        if (res > 32767) res = 32767;
        return q2rm_pkg::t_ent'(res);
    endfunction

    function automatic t_mat rotation_of(t_quat q);
        longint s, i, j, k, ss, ii, jj, kk, n2;
        longint num[q2rm_pkg::N_ENT];
        t_mat   m;
        s = q.s; i = q.i; j = q.j; k = q.k;
        ss = s * s; ii = i * i; jj = j * j; kk = k * k;
        n2 = ss + ii + jj + kk;
        m = '0;
        if (n2 == 0) begin
            m.zn = 1'b1;
            return m;
        end
        num[0] = ss + ii - jj - kk;
        num[1] = 2 * (i * j - s * k);
        num[2] = 2 * (i * k + s * j);
        num[3] = 2 * (i * j + s * k);
        num[4] = ss - ii + jj - kk;
        num[5] = 2 * (j * k - s * i);
        num[6] = 2 * (i * k - s * j);
        num[7] = 2 * (j * k + s * i);
        num[8] = ss - ii - jj + kk;
        for (int e = 0; e < q2rm_pkg::N_ENT; e++) m.ent[e] = round_entry(num[e], n2);
        return m;
    endfunction

    function automatic t_mat ident_mat(int sign);
        t_mat m;
        m = '0;
        m.ent[0] = q2rm_pkg::t_ent'(16384 * sign);
        m.ent[4] = q2rm_pkg::t_ent'(16384 * sign);
        m.ent[8] = q2rm_pkg::t_ent'(16384 * sign);
        return m;
    endfunction

    function automatic t_row mk_row(t_quat q, logic known, t_mat m);
        t_row r;
        r.q = q;
        r.known = known;
        r.m = m;
        return r;
    endfunction

    function automatic q2rm_pkg::t_qin rand_part(int mode);
        case (mode)
            0: return q2rm_pkg::t_qin'($urandom);
            1: return q2rm_pkg::t_qin'($urandom_range(0, 7)) - 16'sd3;
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return q2rm_pkg::t_qin'($urandom_range(0, 511)) - 16'sd256;
        endcase
    endfunction

    function automatic t_quat rand_quat();
        t_quat q;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 6) mode = 0;
        else mode = mode - 6;
        q.s = rand_part(mode);
        q.i = rand_part(mode);
        q.j = rand_part(mode);
        q.k = rand_part(mode);
        if ($urandom_range(0, 19) == 0) q = '0;
        return q;
    endfunction

    task automatic send_quat(t_quat q, t_mat m);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.q_scalar <= q.s;
        req_if.q_i      <= q.i;
        req_if.q_j      <= q.j;
        req_if.q_k      <= q.k;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        matrix_q.push_back(m);
    endtask

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                t_mat got, exp_m;
                got.zn = res_if.zero_norm;
                got.ent = {res_if.m_r2c2, res_if.m_r2c1, res_if.m_r2c0,
                           res_if.m_r1c2, res_if.m_r1c1, res_if.m_r1c0,
                           res_if.m_r0c2, res_if.m_r0c1, res_if.m_r0c0};
                if (matrix_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_cnt++;
                end else begin
                    exp_m = matrix_q.pop_front();
                    for (int e = 0; e < q2rm_pkg::N_ENT; e++)
                        if (got.ent[e] !== exp_m.ent[e]) begin
                            $display("%0t: entry %0d expected %0d actual %0d", $time, e,
                                     exp_m.ent[e], got.ent[e]);
                            fail_cnt++;
                        end
                    if (got.zn !== exp_m.zn) begin
                        $display("%0t: zero_norm expected %b actual %b", $time,
                                 exp_m.zn, got.zn);
                        fail_cnt++;
                    end
                end
            end
            res_if.ready <= !hold_off &&
                            !(recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // long receiver stall while requests keep coming
    initial begin
        hold_off = 1'b0;
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b1;
        for (int c = 0; c < 200; c++) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_row  rows[$];
        t_quat q;
        int    drain;
        fail_cnt = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.q_scalar = '0;
        req_if.q_i = '0;
        req_if.q_j = '0;
        req_if.q_k = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back(mk_row('0, 1'b1, t_mat'(1)));
        rows.push_back(mk_row({16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b1, ident_mat(1)));
        rows.push_back(mk_row({16'sh7fff, 16'sd0, 16'sd0, 16'sd0}, 1'b1, ident_mat(1)));
        rows.push_back(mk_row({16'sh8000, 16'sd0, 16'sd0, 16'sd0}, 1'b1, ident_mat(1)));
        rows.push_back(mk_row({16'sd0, 16'sh8000, 16'sd0, 16'sd0}, 1'b0, '0));
        rows.push_back(mk_row({16'sd0, 16'sd0, 16'sh7fff, 16'sd0}, 1'b0, '0));
        rows.push_back(mk_row({16'sd0, 16'sd0, 16'sd0, 16'sh8000}, 1'b0, '0));
        rows.push_back(mk_row({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0));
        rows.push_back(mk_row({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, '0));
        rows.push_back(mk_row({16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000}, 1'b0, '0));
        rows.push_back(mk_row({16'sd1, 16'sd1, 16'sd0, 16'sd0}, 1'b0, '0));
        rows.push_back(mk_row({16'sd1, 16'sd0, 16'sd1, 16'sd0}, 1'b0, '0));
        rows.push_back(mk_row({16'sd1, 16'sd0, 16'sd0, -16'sd1}, 1'b0, '0));
        rows.push_back(mk_row({16'sd0, 16'sd1, 16'sd2, 16'sd3}, 1'b0, '0));
        rows.push_back(mk_row({16'sd3, 16'sd1, 16'sd1, 16'sd0}, 1'b0, '0));
        rows.push_back(mk_row({-16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b1, ident_mat(1)));
        rows.push_back(mk_row({16'sh5555, 16'shaaaa, 16'sh1234, 16'shedcb}, 1'b0, '0));

        foreach (rows[r])
            send_quat(rows[r].q, rows[r].known ? rows[r].m : rotation_of(rows[r].q));

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 0) begin
                send_idle_pct = 31; recv_idle_pct = 53;
            end else if (n == N_RANDOM / 3) begin
                send_idle_pct = 53; recv_idle_pct = 31;
            end else if (n == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            q = rand_quat();
            send_quat(q, rotation_of(q));
        end
        req_if.valid <= 1'b0;

        drain = 0;
        while (matrix_q.size() != 0 && drain < 100000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (LAT * 2) @(posedge i_clk);
        if (matrix_q.size() != 0) begin
            $display("%0t: %0d results missing", $time, matrix_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
